[src/simple_precedence_parser_defines.svh]
// assertion helpers for the precedence parser
`ifndef SIMPLE_PRECEDENCE_PARSER_DEFINES_SVH
`define SIMPLE_PRECEDENCE_PARSER_DEFINES_SVH

`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/spp_pkg.sv]
package spp_pkg;

  localparam int SYM_W           = 4;
  localparam int NUM_SYMBOLS     = 16;
  localparam int REL_AW          = 2 * SYM_W;
  localparam int STACK_DEPTH     = 32;
  localparam int STK_AW          = 5;
  localparam int CNT_W           = 6;
  localparam int NUM_PRODUCTIONS = 16;
  localparam int PROD_AW         = 4;
  localparam int MAX_RHS         = 4;
  localparam int LEN_W           = 3;
  localparam int MAX_REDUCTIONS  = 62;
  localparam int RED_W           = 6;

  typedef enum logic [1:0] {
    FUNC_REL   = 2'd0,
    FUNC_PROD  = 2'd1,
    FUNC_PARSE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REL_ERROR   = 2'd0,
    REL_LESS    = 2'd1,
    REL_EQUAL   = 2'd2,
    REL_GREATER = 2'd3
  } rel_t;

  typedef enum logic [2:0] {
    K_SHIFT    = 3'd0,
    K_REDUCE   = 3'd1,
    K_ACCEPT   = 3'd2,
    K_NOREL    = 3'd3,
    K_NOMATCH  = 3'd4,
    K_OVERFLOW = 3'd5,
    K_LOADED   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_DEC,
    ST_WRD,
    ST_WREL,
    ST_WCHK,
    ST_PRD,
    ST_PCHK
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  rel_row;
    logic [3:0]  rel_col;
    logic [1:0]  rel_value;
    logic [3:0]  prod_slot;
    logic [3:0]  prod_left;
    logic [2:0]  prod_len;
    logic [15:0] prod_rhs;
    logic [3:0]  symbol;
    logic        is_end;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] prod_used;
    logic [3:0] new_top;
    logic [5:0] stack_level;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [SYM_W-1:0]           left;
    logic [LEN_W-1:0]           len;
    logic [MAX_RHS*SYM_W-1:0]   rhs;
  } prod_t;

endpackage

[src/simple_precedence_parser.sv]
// Shift-reduce parser for simple precedence grammars. Raise start for one
// item while busy is low; busy stays high while a parse item is worked on
// and falls as its last result is issued, and a table load leaves it low.
// Results appear on out_item for exactly one cycle with out_valid and
// cannot be stalled, so the receiver must take every one; out_item.last
// marks the final result of an item. A parse item starts with a relation
// lookup of the stack top against the new symbol. Each reduction walks
// the handle symbol by symbol (stack memory read followed by relation
// memory read), scans the production slots in the production memory until
// one matches, and looks up the relation against the new stack top.
// cfg_ready is always high, so a start symbol write is taken at any edge;
// write it only while busy is low and no result is still due.
`include "simple_precedence_parser_defines.svh"

module simple_precedence_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  spp_pkg::in_t          in_item,
  output logic                  out_valid,
  output spp_pkg::out_t         out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);
  import spp_pkg::*;

  state_t state_r, state_nxt;

  logic [SYM_W-1:0] start_sym_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SYM_W-1:0] top_r, top_nxt;
  logic [STK_AW-1:0] k_r, k_nxt;
  logic [LEN_W-1:0] hlen_r, hlen_nxt;
  logic [SYM_W-1:0] hbuf_r [MAX_RHS];
  logic [SYM_W-1:0] hbuf_nxt [MAX_RHS];
  logic [PROD_AW-1:0] p_r, p_nxt;
  logic [RED_W-1:0] reds_r, reds_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic end_r, end_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  // symbol stack memory
  logic [SYM_W-1:0] stk_mem [STACK_DEPTH];
  logic stk_we;
  logic [STK_AW-1:0] stk_wa, stk_ra;
  logic [SYM_W-1:0] stk_wd, stk_q_r;

  // relation memory
  logic [1:0] rel_mem [NUM_SYMBOLS*NUM_SYMBOLS];
  logic [NUM_SYMBOLS*NUM_SYMBOLS-1:0] rel_vld_r;
  logic rel_we;
  logic [REL_AW-1:0] rel_wa, rel_ra;
  logic [1:0] rel_q_r;
  logic rel_qv_r;
  rel_t rel_cur;

  // production memory
  prod_t prod_mem [NUM_PRODUCTIONS];
  logic [NUM_PRODUCTIONS-1:0] prod_vld_r;
  logic prod_we;
  prod_t prod_wd, prod_q_r;
  logic prod_qv_r;
  logic prod_match;

  logic [SYM_W-1:0] cur_top;
  logic [LEN_W-1:0] sat_len;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign rel_cur = rel_qv_r ? rel_t'(rel_q_r) : REL_ERROR;
  assign cur_top = (cnt_r != '0) ? top_r : '0;
  assign stk_ra  = k_r - STK_AW'(1);
  assign rel_ra  = (state_r == ST_WREL) ? {stk_q_r, hbuf_r[0]} : {top_r, sym_r};
  assign sat_len = (in_item.prod_len > LEN_W'(MAX_RHS)) ? LEN_W'(MAX_RHS) : in_item.prod_len;

  always_comb begin
    prod_match = prod_qv_r && (prod_q_r.len == hlen_r);
    for (int i = 0; i < MAX_RHS; i++) begin
      if ((LEN_W'(i) < hlen_r) && (prod_q_r.rhs[i*SYM_W +: SYM_W] != hbuf_r[i])) begin
        prod_match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_sym_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_sym_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[rel_wa] <= in_item.rel_value;
    end
    rel_q_r <= rel_mem[rel_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_vld_r <= '0;
      rel_qv_r  <= 1'b0;
    end else begin
      if (rel_we) begin
        rel_vld_r[rel_wa] <= 1'b1;
      end
      rel_qv_r <= rel_vld_r[rel_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[in_item.prod_slot] <= prod_wd;
    end
    prod_q_r <= prod_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= '0;
      prod_qv_r  <= 1'b0;
    end else begin
      if (prod_we) begin
        prod_vld_r[in_item.prod_slot] <= 1'b1;
      end
      prod_qv_r <= prod_vld_r[p_r];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (func_t'(in_item.func) == FUNC_PARSE)) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: state_nxt = ST_DEC;
      ST_DEC: begin
        if (end_r) begin
          if (cnt_r == '0 || (cnt_r == CNT_W'(1) && top_r == start_sym_r)) begin
            state_nxt = ST_IDLE;
          end else if (reds_r >= RED_W'(MAX_REDUCTIONS)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WRD;
          end
        end else if (cnt_r != '0 && rel_cur == REL_GREATER
                     && reds_r < RED_W'(MAX_REDUCTIONS)) begin
          state_nxt = ST_WRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRD:  state_nxt = (k_r == '0) ? ST_PRD : ST_WREL;
      ST_WREL: state_nxt = ST_WCHK;
      ST_WCHK: begin
        if (rel_cur == REL_EQUAL) begin
          state_nxt = (hlen_r == LEN_W'(MAX_RHS)) ? ST_IDLE : ST_WRD;
        end else begin
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: state_nxt = ST_PCHK;
      ST_PCHK: begin
        if (prod_match) begin
          state_nxt = ST_REL;
        end else if (p_r == PROD_AW'(NUM_PRODUCTIONS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    k_nxt         = k_r;
    hlen_nxt      = hlen_r;
    hbuf_nxt      = hbuf_r;
    p_nxt         = p_r;
    reds_nxt      = reds_r;
    sym_nxt       = sym_r;
    end_nxt       = end_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    stk_we        = 1'b0;
    stk_wa        = cnt_r[STK_AW-1:0];
    stk_wd        = sym_r;
    rel_we        = 1'b0;
    rel_wa        = {in_item.rel_row, in_item.rel_col};
    prod_we       = 1'b0;
    prod_wd       = '{left: in_item.prod_left, len: sat_len, rhs: in_item.prod_rhs};
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (func_t'(in_item.func) == FUNC_PARSE) begin
            sym_nxt  = in_item.symbol;
            end_nxt  = in_item.is_end;
            reds_nxt = '0;
          end else begin
            rel_we        = (func_t'(in_item.func) == FUNC_REL);
            prod_we       = (func_t'(in_item.func) == FUNC_PROD);
            out_valid_nxt = 1'b1;
            out_nxt       = '{kind: K_LOADED, prod_used: '0, new_top: cur_top,
                              stack_level: cnt_r, last: 1'b1};
          end
        end
      end
      ST_DEC: begin
        out_nxt = '{kind: K_NOMATCH, prod_used: '0, new_top: cur_top,
                    stack_level: cnt_r, last: 1'b1};
        if (end_r) begin
          if (cnt_r == CNT_W'(1) && top_r == start_sym_r) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind  = K_ACCEPT;
            cnt_nxt       = '0;
          end else if (cnt_r == '0) begin
            out_valid_nxt = 1'b1;
          end else if (reds_r >= RED_W'(MAX_REDUCTIONS)) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind  = K_OVERFLOW;
            cnt_nxt       = '0;
          end
        end else if (cnt_r != '0 && rel_cur == REL_ERROR) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = K_NOREL;
          cnt_nxt       = '0;
        end else if (cnt_r != '0 && rel_cur == REL_GREATER) begin
          if (reds_r >= RED_W'(MAX_REDUCTIONS)) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind  = K_OVERFLOW;
            cnt_nxt       = '0;
          end
        end else if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = K_OVERFLOW;
          cnt_nxt       = '0;
        end else begin
          stk_we        = 1'b1;
          cnt_nxt       = cnt_r + CNT_W'(1);
          top_nxt       = sym_r;
          out_valid_nxt = 1'b1;
          out_nxt       = '{kind: K_SHIFT, prod_used: '0, new_top: sym_r,
                            stack_level: cnt_r + CNT_W'(1), last: 1'b1};
        end
        // handle walk starts at the stack top
        k_nxt       = STK_AW'(cnt_r - CNT_W'(1));
        hlen_nxt    = LEN_W'(1);
        hbuf_nxt[0] = top_r;
        p_nxt       = '0;
      end
      ST_WCHK: begin
        if (rel_cur == REL_EQUAL) begin
          if (hlen_r == LEN_W'(MAX_RHS)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{kind: K_NOMATCH, prod_used: '0, new_top: cur_top,
                              stack_level: cnt_r, last: 1'b1};
            cnt_nxt       = '0;
          end else begin
            for (int i = 1; i < MAX_RHS; i++) begin
              hbuf_nxt[i] = hbuf_r[i-1];
            end
            hbuf_nxt[0] = stk_q_r;
            hlen_nxt    = hlen_r + LEN_W'(1);
            k_nxt       = k_r - STK_AW'(1);
          end
        end
        p_nxt = '0;
      end
      ST_PCHK: begin
        if (prod_match) begin
          stk_we        = 1'b1;
          stk_wa        = k_r;
          stk_wd        = prod_q_r.left;
          cnt_nxt       = CNT_W'(k_r) + CNT_W'(1);
          top_nxt       = prod_q_r.left;
          reds_nxt      = reds_r + RED_W'(1);
          out_valid_nxt = 1'b1;
          out_nxt       = '{kind: K_REDUCE, prod_used: p_r, new_top: prod_q_r.left,
                            stack_level: CNT_W'(k_r) + CNT_W'(1), last: 1'b0};
        end else if (p_r == PROD_AW'(NUM_PRODUCTIONS - 1)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{kind: K_NOMATCH, prod_used: '0, new_top: cur_top,
                            stack_level: cnt_r, last: 1'b1};
          cnt_nxt       = '0;
        end else begin
          p_nxt = p_r + PROD_AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      reds_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      reds_r      <= reds_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    k_r    <= k_nxt;
    hlen_r <= hlen_nxt;
    hbuf_r <= hbuf_nxt;
    p_r    <= p_nxt;
    sym_r  <= sym_nxt;
    end_r  <= end_nxt;
    out_r  <= out_nxt;
  end

  `SPP_ASSERT(a_cnt_range, cnt_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `SPP_ASSERT(a_reds_range, reds_r <= RED_W'(MAX_REDUCTIONS), "reduction count beyond budget")
  `SPP_ASSERT(a_more_follows, out_valid_r && !out_r.last |-> busy, "idle before last result")
  `SPP_ASSERT(a_accept_level,
              out_valid_r && out_r.kind == K_ACCEPT |->
              out_r.stack_level == CNT_W'(1) && cnt_r == '0,
              "accept with wrong level")
  `SPP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r && !busy, "activity after reset")

endmodule

[tb/sv/tb.sv]
module tb;
  import spp_pkg::*;

  class parse_scoreboard;
    logic [3:0] stk [STACK_DEPTH];
    int         depth;
    logic [1:0] rel_tab [256];
    prod_t      prods [NUM_PRODUCTIONS];
    logic [3:0] start_sym;
    out_t       expected_q [$];
    int         errors;

    function new();
      for (int i = 0; i < 256; i++) rel_tab[i] = REL_ERROR;
      for (int i = 0; i < NUM_PRODUCTIONS; i++) prods[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
      depth = 0;
      start_sym = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_result(kind_t k, logic [3:0] p, logic l);
      out_t r;
      r.kind = k;
      r.prod_used = p;
      r.new_top = (depth != 0) ? stk[depth-1] : 4'd0;
      r.stack_level = depth[5:0];
      r.last = l;
      expected_q = {expected_q, r};
    endfunction

    function void push_error(kind_t k);
      push_result(k, 4'd0, 1'b1);
      depth = 0;
    endfunction

    function int reduce_top();
      int  k;
      int  len;
      bit  ok;
      k = depth - 1;
      while (k > 0 && rel_tab[{stk[k-1], stk[k]}] == REL_EQUAL) k--;
      len = depth - k;
      if (len > MAX_RHS) return -1;
      for (int p = 0; p < NUM_PRODUCTIONS; p++) begin
        ok = (prods[p].len == len);
        for (int i = 0; i < len; i++)
          if (prods[p].rhs[i*4 +: 4] != stk[k+i]) ok = 0;
        if (ok) begin
          stk[k] = prods[p].left;
          depth = k + 1;
          return p;
        end
      end
      return -1;
    endfunction

    function void parse_symbol(logic [3:0] sym, logic fin);
      int         reds;
      int         p;
      bit         do_red;
      logic [1:0] r;
      reds = 0;
      forever begin
        if (fin) begin
          if (depth == 1 && stk[0] == start_sym) begin
            push_result(K_ACCEPT, 4'd0, 1'b1);
            depth = 0;
            return;
          end
          if (depth == 0) begin
            push_error(K_NOMATCH);
            return;
          end
          do_red = 1;
        end else begin
          r = (depth != 0) ? rel_tab[{stk[depth-1], sym}] : REL_LESS;
          if (r == REL_ERROR) begin
            push_error(K_NOREL);
            return;
          end
          do_red = (r == REL_GREATER);
        end
        if (!do_red) break;
        if (reds >= MAX_REDUCTIONS) begin
          push_error(K_OVERFLOW);
          return;
        end
        p = reduce_top();
        if (p < 0) begin
          push_error(K_NOMATCH);
          return;
        end
        push_result(K_REDUCE, p[3:0], 1'b0);
        reds++;
      end
      if (depth >= STACK_DEPTH) begin
        push_error(K_OVERFLOW);
        return;
      end
      stk[depth] = sym;
      depth++;
      push_result(K_SHIFT, 4'd0, 1'b1);
    endfunction

    function void note_item(in_t it);
      logic [2:0] len;
      case (it.func)
        FUNC_REL: rel_tab[{it.rel_row, it.rel_col}] = it.rel_value;
        FUNC_PROD: begin
          len = (it.prod_len > MAX_RHS) ? 3'(MAX_RHS) : it.prod_len;
          prods[it.prod_slot].left = it.prod_left;
          prods[it.prod_slot].len = len;
          prods[it.prod_slot].rhs = it.prod_rhs;
        end
        FUNC_PARSE: begin
          parse_symbol(it.symbol, it.is_end);
          return;
        end
        default: ;
      endcase
      push_result(K_LOADED, 4'd0, 1'b1);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result kind=%0d top=%0d level=%0d", got.kind, got.new_top,
                   got.stack_level);
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind || got.prod_used !== exp.prod_used ||
          got.new_top !== exp.new_top || got.stack_level !== exp.stack_level ||
          got.last !== exp.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k=%0d p=%0d t=%0d l=%0d e=%0d got k=%0d p=%0d t=%0d l=%0d e=%0d",
                   exp.kind, exp.prod_used, exp.new_top, exp.stack_level, exp.last,
                   got.kind, got.prod_used, got.new_top, got.stack_level, got.last);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       start = 0;
  logic       busy;
  in_t        in_item = '0;
  logic       out_valid;
  out_t       out_item;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;

  parse_scoreboard sb = new();
  int idle_cycles = 0;
  int n_sent = 0;
  int burst_left = 0;

  simple_precedence_parser u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_item(in_item);
      if (cfg_valid && cfg_ready) sb.start_sym = cfg_data;
    end
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t rnd_item();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return in_t'(v[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t rel_item(logic [3:0] r, logic [3:0] c, rel_t v);
    in_t it;
    it = rnd_item();
    it.func = FUNC_REL;
    it.rel_row = r;
    it.rel_col = c;
    it.rel_value = v;
    return it;
  endfunction

  function automatic in_t prod_item(logic [3:0] s, logic [3:0] l, logic [2:0] n,
                                    logic [15:0] rhs);
    in_t it;
    it = rnd_item();
    it.func = FUNC_PROD;
    it.prod_slot = s;
    it.prod_left = l;
    it.prod_len = n;
    it.prod_rhs = rhs;
    return it;
  endfunction

  function automatic in_t sym_item(logic [3:0] s, logic fin);
    in_t it;
    it = rnd_item();
    it.func = FUNC_PARSE;
    it.symbol = s;
    it.is_end = fin;
    return it;
  endfunction

  task automatic send_item(in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    start <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start_symbol(logic [3:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic run_string(logic [3:0] a, logic [3:0] b, logic [3:0] c, int n,
                            bit corrupt);
    logic [3:0] seq [$];
    for (int i = 0; i < n; i++) seq = {seq, a};
    seq = {seq, c};
    for (int i = 0; i < n; i++) seq = {seq, b};
    if (corrupt) seq[$urandom_range(0, seq.size() - 1)] = 4'($urandom);
    foreach (seq[i]) send_item(sym_item(seq[i], 1'b0));
    send_item(sym_item(4'($urandom), 1'b1));
  endtask

  initial begin
    logic [3:0] s_sym, a_sym, b_sym, c_sym;
    in_t        it;
    int         slot_a, slot_c;

    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_start_symbol(4'd15);

    it = rnd_item();
    it.func = FUNC_NOP;
    send_item(it);
    send_item(rel_item(4'd0, 4'd15, REL_GREATER));
    send_item(rel_item(4'd15, 4'd0, REL_EQUAL));
    send_item(prod_item(4'd15, 4'd15, 3'd7, 16'hFFFF));
    send_item(prod_item(4'd14, 4'd3, 3'd0, 16'h0000));
    send_item(sym_item(4'd0, 1'b1));
    send_item(sym_item(4'd7, 1'b0));
    send_item(sym_item(4'd3, 1'b0));
    send_item(prod_item(4'd0, 4'd5, 3'd1, 16'h0005));
    send_item(sym_item(4'd5, 1'b0));
    send_item(sym_item(4'd0, 1'b1));
    send_item(rel_item(4'd5, 4'd5, REL_EQUAL));
    repeat (5) send_item(sym_item(4'd5, 1'b0));
    send_item(sym_item(4'd0, 1'b1));
    wait_idle();
    write_start_symbol(4'd5);
    send_item(sym_item(4'd5, 1'b0));
    send_item(sym_item(4'd9, 1'b1));
    wait_idle();
    write_start_symbol(4'd0);

    while (n_sent < 480) begin
      s_sym = 4'($urandom);
      do a_sym = 4'($urandom); while (a_sym == s_sym);
      do b_sym = 4'($urandom); while (b_sym == s_sym || b_sym == a_sym);
      do c_sym = 4'($urandom); while (c_sym == s_sym || c_sym == a_sym || c_sym == b_sym);
      write_start_symbol(($urandom_range(0, 4) == 0) ? 4'($urandom) : s_sym);
      slot_a = $urandom_range(0, 15);
      do slot_c = $urandom_range(0, 15); while (slot_c == slot_a);
      send_item(rel_item(a_sym, a_sym, REL_LESS));
      send_item(rel_item(a_sym, c_sym, REL_LESS));
      send_item(rel_item(a_sym, s_sym, REL_EQUAL));
      send_item(rel_item(s_sym, b_sym, REL_EQUAL));
      send_item(rel_item(b_sym, b_sym, REL_GREATER));
      send_item(rel_item(c_sym, b_sym, REL_GREATER));
      send_item(prod_item(slot_a[3:0], s_sym, 3'd3, {4'($urandom), b_sym, s_sym, a_sym}));
      send_item(prod_item(slot_c[3:0], s_sym, 3'd1, {12'($urandom), c_sym}));
      repeat ($urandom_range(3, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(rnd_item());
        end
        if ($urandom_range(0, 14) == 0) run_string(a_sym, b_sym, c_sym, 33, 1'b0);
        else run_string(a_sym, b_sym, c_sym, $urandom_range(0, 10),
                        $urandom_range(0, 4) == 0);
      end
      wait_idle();
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/spp_pkg.sv
src/simple_precedence_parser.sv
tb/sv/tb.sv
